[rtl/bf3_pkg.sv]
// Shared types, register indexes and tap arithmetic for the 3x3 RGB box filter.
package bf3_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Image size reset values
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;

  // floor(n / 9) for n <= 259 is (n * 57) >> 9
  localparam logic [5:0] TAP_RECIP = 6'd57;
  localparam int         TAP_SHIFT = 9;

  // One pixel, red in the low byte
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  // Three-row column sum of rounded taps, one field per channel
  typedef struct packed {
    logic [6:0] blue;
    logic [6:0] green;
    logic [6:0] red;
  } csum_t;

  // One tap rounded to nearest: floor((p + 4) / 9), at most 28
  function automatic logic [4:0] tap(input logic [7:0] p);
    logic [8:0]  n;
    logic [14:0] prod;
    n    = {1'b0, p} + 9'd4;
    prod = n * TAP_RECIP;
    return prod[TAP_SHIFT+4:TAP_SHIFT];
  endfunction

endpackage

[rtl/bf3_line_buf.sv]
// Two line buffers (even and odd rows) with a shared address and registered reads.
module bf3_line_buf #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic              clk,
  input  logic              en,
  input  logic              wr_odd,
  input  logic [AW-1:0]     addr,
  input  bf3_pkg::pixel_t   wr_data,
  output bf3_pkg::pixel_t   rd_even,
  output bf3_pkg::pixel_t   rd_odd
);
  import bf3_pkg::*;

  pixel_t mem_even_r [DEPTH];
  pixel_t mem_odd_r  [DEPTH];
  pixel_t rd_even_r;
  pixel_t rd_odd_r;

  // Read old contents of both rows, then store the new pixel into its row
  always_ff @(posedge clk) begin
    if (en) begin
      rd_even_r <= mem_even_r[addr];
      rd_odd_r  <= mem_odd_r[addr];
      if (wr_odd) begin
        mem_odd_r[addr] <= wr_data;
      end else begin
        mem_even_r[addr] <= wr_data;
      end
    end
  end

  assign rd_even = rd_even_r;
  assign rd_odd  = rd_odd_r;

endmodule

[rtl/box_filter_3x3_rgb_unit.sv]
// Top level of the 3x3 mean filter for RGB pixel streams.
// Sustains one pixel per clock: a transferred pixel waits in the input register, then
// moves into the output register, from which its result is transferred out. The input
// stalls only while an interior pixel in the input register waits behind a held result
// in the output register. Throughput is set by the line buffer read port, which is read
// once per accepted pixel. Each input pixel at row >= 2 and column >= 2 yields the
// filtered pixel centred one row up and one column left; border pixels yield nothing.
// The line buffers need no clearing after reset. Any configuration write restarts the image.
module box_filter_3x3_rgb_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input pixel stream
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [23:0]                     in_tdata,   // red_in, green_in, blue_in
  // Filtered pixel stream
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // red_out, green_out, blue_out
  output logic                            out_tlast,  // last_pixel
  // Configuration writes
  input  logic                            cfg_wen,
  input  logic [bf3_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bf3_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import bf3_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);

  typedef struct packed {
    logic row_odd;
    logic upd;
    logic emit;
    logic last;
  } a_ctl_t;

  logic [12:0]   image_width_r;
  logic [15:0]   image_height_r;
  logic [XW-1:0] col_r;
  logic [15:0]   row_r;
  logic [XW-1:0] w_last;
  logic [15:0]   h_last;
  logic          in_xfer;

  logic          valid_a_r;
  a_ctl_t        ctl_a_r;
  a_ctl_t        ctl_a_nxt;
  pixel_t        cur_a_r;
  pixel_t        rd_even;
  pixel_t        rd_odd;
  pixel_t        top;
  pixel_t        mid;
  logic          adv_a;

  csum_t         cs0_r;
  csum_t         cs1_r;
  csum_t         col_nxt;
  pixel_t        res_nxt;

  logic          out_valid_r;
  pixel_t        out_pix_r;
  logic          out_last_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RESET;
      image_height_r <= HEIGHT_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[12:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Effective last column and last row after clamping
  always_comb begin
    if (image_width_r < 13'd3) begin
      w_last = XW'(2);
    end else if (32'(image_width_r) > MAX_WIDTH) begin
      w_last = XW'(MAX_WIDTH - 1);
    end else begin
      w_last = XW'(image_width_r - 13'd1);
    end
    h_last = (image_height_r < 16'd3) ? 16'd2 : image_height_r - 16'd1;
  end

  assign in_xfer = in_tvalid && in_tready;

  // Raster position of the next pixel
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wen) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_xfer) begin
      if (col_r == w_last) begin
        col_r <= '0;
        row_r <= (row_r == h_last) ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + XW'(1);
      end
    end
  end

  always_comb begin
    ctl_a_nxt.row_odd = row_r[0];
    ctl_a_nxt.upd     = row_r >= 16'd2;
    ctl_a_nxt.emit    = (row_r >= 16'd2) && (col_r >= XW'(2));
    ctl_a_nxt.last    = (row_r == h_last) && (col_r == w_last);
  end

  bf3_line_buf #(
    .DEPTH (MAX_WIDTH),
    .AW    (XW)
  ) u_line_buf (
    .clk     (clk),
    .en      (in_xfer),
    .wr_odd  (row_r[0]),
    .addr    (col_r),
    .wr_data (pixel_t'(in_tdata)),
    .rd_even (rd_even),
    .rd_odd  (rd_odd)
  );

  // Input stage: moves on unless its result would land on a held output
  assign adv_a     = valid_a_r && (!ctl_a_r.emit || !out_valid_r || out_tready);
  assign in_tready = !valid_a_r || adv_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_a_r <= 1'b0;
    end else if (in_xfer) begin
      valid_a_r <= 1'b1;
    end else if (adv_a) begin
      valid_a_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      ctl_a_r <= ctl_a_nxt;
      cur_a_r <= pixel_t'(in_tdata);
    end
  end

  // Row y-2 sits in the buffer of the same parity, row y-1 in the other
  assign top = ctl_a_r.row_odd ? rd_odd  : rd_even;
  assign mid = ctl_a_r.row_odd ? rd_even : rd_odd;

  // New column sum and the 3x3 result
  always_comb begin
    col_nxt.red   = 7'(tap(top.red))   + 7'(tap(mid.red))   + 7'(tap(cur_a_r.red));
    col_nxt.green = 7'(tap(top.green)) + 7'(tap(mid.green)) + 7'(tap(cur_a_r.green));
    col_nxt.blue  = 7'(tap(top.blue))  + 7'(tap(mid.blue))  + 7'(tap(cur_a_r.blue));
    res_nxt.red   = 8'(cs0_r.red)   + 8'(cs1_r.red)   + 8'(col_nxt.red);
    res_nxt.green = 8'(cs0_r.green) + 8'(cs1_r.green) + 8'(col_nxt.green);
    res_nxt.blue  = 8'(cs0_r.blue)  + 8'(cs1_r.blue)  + 8'(col_nxt.blue);
  end

  // Column sums of the two previous columns
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wen) begin
      cs0_r <= '0;
      cs1_r <= '0;
    end else if (adv_a && ctl_a_r.upd) begin
      cs0_r <= cs1_r;
      cs1_r <= col_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv_a && ctl_a_r.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_a && ctl_a_r.emit) begin
      out_pix_r  <= res_nxt;
      out_last_r <= ctl_a_r.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_pix_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/bf3_checker.sv]
// Port-level checks for the 3x3 RGB box filter, bound to the top level.
module bf3_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tlast
);

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output changed while stalled");

  // Reset empties the output register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // A result appearing on an empty output comes from a pixel that passed the input register without waiting
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input transfer");

  // A ready sink never blocks the input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled with ready sink");

endmodule

bind box_filter_3x3_rgb_unit bf3_checker u_bf3_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

[tb/sv/tb.sv]
// Self-checking testbench for the 3x3 RGB box filter: random pixel streams, bit-exact predictor.
module tb;
  import bf3_pkg::*;

  localparam int MAXW          = 4096;
  localparam int IDLE_LIMIT    = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS  = 400;

  // Indexes past the register list; a write there still restarts the image
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  // Channel values around the rounding steps of one tap
  localparam logic [7:0] EDGE_VALS [11] = '{8'd0, 8'd4, 8'd5, 8'd13, 8'd14, 8'd247,
                                            8'd248, 8'd250, 8'd251, 8'd254, 8'd255};

  typedef struct {
    pixel_t px;
    logic   last;
  } filtered_t;

  // Mean-filter predictor and queue of filtered pixels still owed by the block
  class box_mean_predictor;
    logic [12:0] width_reg;
    logic [15:0] height_reg;
    pixel_t      line_mem [2*MAXW];
    csum_t       col_sums [2];
    int unsigned col_pos;
    int unsigned row_pos;
    filtered_t   expected_pixels [$];
    int          mismatches;

    function new();
      width_reg  = WIDTH_RESET;
      height_reg = HEIGHT_RESET;
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      col_sums[0] = '0;
      col_sums[1] = '0;
      col_pos     = 0;
      row_pos     = 0;
    endfunction

    function void apply_reg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_IMAGE_WIDTH) width_reg = data[12:0];
      else if (idx == REG_IMAGE_HEIGHT) height_reg = data;
      restart();
    endfunction

    // p/9 rounded to nearest
    static function logic [6:0] ninth(logic [7:0] p);
      return 7'((int'(p) + 4) / 9);
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction

    // Accepted input pixel: update windows, queue a result for interior positions
    function void note_pixel_in(pixel_t cur);
      int unsigned w, h, here, above;
      pixel_t      top, mid;
      csum_t       col;
      filtered_t   res;
      w = (width_reg < 3) ? 3 : (width_reg > MAXW) ? MAXW : int'(width_reg);
      h = (height_reg < 3) ? 3 : int'(height_reg);
      here  = (row_pos % 2) * MAXW + col_pos;
      above = ((row_pos + 1) % 2) * MAXW + col_pos;
      if (row_pos >= 2) begin
        top = line_mem[here];
        mid = line_mem[above];
        col.red   = ninth(top.red)   + ninth(mid.red)   + ninth(cur.red);
        col.green = ninth(top.green) + ninth(mid.green) + ninth(cur.green);
        col.blue  = ninth(top.blue)  + ninth(mid.blue)  + ninth(cur.blue);
        if (col_pos >= 2) begin
          res.px.red   = 8'(col_sums[0].red)   + 8'(col_sums[1].red)   + 8'(col.red);
          res.px.green = 8'(col_sums[0].green) + 8'(col_sums[1].green) + 8'(col.green);
          res.px.blue  = 8'(col_sums[0].blue)  + 8'(col_sums[1].blue)  + 8'(col.blue);
          res.last     = (row_pos == h - 1) && (col_pos == w - 1);
          expected_pixels.push_back(res);
        end
        col_sums[0] = col_sums[1];
        col_sums[1] = col;
      end
      line_mem[here] = cur;
      col_pos++;
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // Accepted output pixel against the oldest expectation
    task check_pixel_out(pixel_t px, logic last);
      filtered_t want;
      if (expected_pixels.size() == 0) begin
        flag_mismatch($sformatf("output pixel %h with nothing pending", px));
        return;
      end
      want = expected_pixels.pop_front();
      if (px.red !== want.px.red)
        flag_mismatch($sformatf("red %0d, want %0d", px.red, want.px.red));
      if (px.green !== want.px.green)
        flag_mismatch($sformatf("green %0d, want %0d", px.green, want.px.green));
      if (px.blue !== want.px.blue)
        flag_mismatch($sformatf("blue %0d, want %0d", px.blue, want.px.blue));
      if (last !== want.last)
        flag_mismatch($sformatf("last %0b, want %0b", last, want.last));
    endtask
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  pixel_t                in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [23:0]           out_tdata;
  logic                  out_tlast;
  logic                  cfg_wen    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  box_mean_predictor sb = new();

  int burst_left  = 0;
  bit gaps_on     = 1'b1;
  int items_sent  = 0;
  int idle_cycles = 0;
  logic [15:0] ready_pat = '1;
  int pat_pos = 0;

  box_filter_3x3_rgb_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Monitor: result transfers, input transfers and register writes at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_pixel_out(out_tdata, out_tlast);
      if (in_tvalid && in_tready) sb.note_pixel_in(in_tdata);
      if (cfg_wen) sb.apply_reg_write(cfg_index, cfg_wdata);
    end
  end

  // Receiver backpressure: a 16-bit ready pattern, reshuffled every few rounds
  always @(negedge clk) begin
    if (pat_pos == 0) begin
      if ($urandom_range(0, 3) == 0) ready_pat = '1;
      else ready_pat = 16'($urandom) | 16'h1;
    end
    out_tready <= ready_pat[pat_pos % 16];
    pat_pos = (pat_pos + 1) % 112;
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [7:0] pick_channel(int mode);
    if (mode == 1 || (mode == 2 && $urandom_range(0, 1) == 1))
      return EDGE_VALS[$urandom_range(0, 10)];
    return 8'($urandom);
  endfunction

  // mode 0: uniform, 1: rounding-edge values, 2: mix of both
  function automatic pixel_t pick_pixel(int mode);
    pixel_t p;
    p.red   = pick_channel(mode);
    p.green = pick_channel(mode);
    p.blue  = pick_channel(mode);
    return p;
  endfunction

  // One input transfer, with a random gap at each burst boundary when gaps are on
  task send_pixel(input pixel_t p);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk) in_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      burst_left = $urandom_range(1, 40);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  // Hold input, wait for every owed result, then let the pipeline settle
  task drain();
    @(negedge clk) in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    drain();
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk) cfg_wen <= 1'b0;
  endtask

  task send_frame(input int count, input int mode);
    repeat (count) send_pixel(pick_pixel(mode));
  endtask

  initial begin
    int w, h, eff_w, eff_h, total, cut, mode, r, start_items;
    pixel_t p;

    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Reset sizes: the first pixels of row zero, which yield nothing
    send_frame(24, 0);

    // Directed: 3x3 image of full-scale pixels
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    p = '{blue: 8'hFF, green: 8'hFF, red: 8'hFF};
    repeat (9) send_pixel(p);
    // Directed: rounding-edge values walked across the channels
    for (int i = 0; i < 9; i++) begin
      p.red   = EDGE_VALS[i % 11];
      p.green = EDGE_VALS[(i + 3) % 11];
      p.blue  = EDGE_VALS[(i + 7) % 11];
      send_pixel(p);
    end
    // Directed: sizes below the minimum act as 3x3
    write_reg(REG_IMAGE_WIDTH, 16'd0);
    write_reg(REG_IMAGE_HEIGHT, 16'd2);
    send_frame(9, 1);

    // Random images
    start_items = items_sent;
    while (items_sent < start_items + RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      w = (r == 0) ? $urandom_range(0, 2) : (r == 1) ? $urandom_range(13, 40)
                                                    : $urandom_range(3, 12);
      r = $urandom_range(0, 9);
      h = (r == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
      eff_w = (w < 3) ? 3 : w;
      eff_h = (h < 3) ? 3 : h;
      gaps_on = ($urandom_range(0, 3) != 0);
      mode = $urandom_range(0, 2);
      if ($urandom_range(0, 1) == 1) begin
        write_reg(REG_IMAGE_WIDTH, {3'($urandom_range(0, 7)), 13'(w)});
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
      end else begin
        write_reg(REG_IMAGE_HEIGHT, 16'(h));
        write_reg(REG_IMAGE_WIDTH, {3'($urandom_range(0, 7)), 13'(w)});
      end
      if ($urandom_range(0, 4) == 0) write_reg(REG_SPARE_A, 16'($urandom));

      r = $urandom_range(0, 9);
      if (r < 6) total = $urandom_range(1, 2) * eff_w * eff_h;
      else total = $urandom_range(1, eff_w * eff_h - 1);
      // Broken image: restart partway, then run a complete one
      cut = (r >= 8) ? $urandom_range(1, eff_w * eff_h - 1) : -1;
      if (r >= 8) total = cut + eff_w * eff_h;
      for (int i = 0; i < total; i++) begin
        if (items_sent >= start_items + RANDOM_ITEMS) break;
        if (i == cut) write_reg($urandom_range(0, 1) ? REG_SPARE_B : REG_SPARE_A,
                                16'($urandom));
        else if ($urandom_range(0, 63) == 0) drain();
        send_pixel(pick_pixel(mode));
      end
    end

    // Width above the maximum: the first pixels of its first row
    gaps_on = 1'b1;
    write_reg(REG_IMAGE_WIDTH, 16'hFFFF);
    write_reg(REG_IMAGE_HEIGHT, 16'd3);
    send_frame(64, 0);

    // Tallest image, only its first rows
    write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
    write_reg(REG_IMAGE_WIDTH, 16'd3);
    send_frame(3 * 40, 2);

    drain();
    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d output pixels never arrived", sb.pending()));
    if (sb.mismatches == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
